// ===== rtl/core/cftg_pkg.sv =====
package cftg_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  localparam logic [2:0] FMT_YUYV   = 3'd0;
  localparam logic [2:0] FMT_PLANAR = 3'd1;
  localparam logic [2:0] FMT_RGB    = 3'd2;
  localparam logic [2:0] FMT_BGR    = 3'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  localparam logic [2:0]  RST_FORMAT = FMT_YUYV;
  localparam logic [12:0] RST_WIDTH  = 13'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;

  localparam logic [15:0] COEF_R = 16'd16843;
  localparam logic [15:0] COEF_G = 16'd33030;
  localparam logic [15:0] COEF_B = 16'd6423;
  localparam logic [24:0] LUMA_OFFSET = 25'd1048576;

  typedef struct packed {
    logic [2:0]  format;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic       luma;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
    logic       ok;
  } job_t;

endpackage

// ===== rtl/core/cftg_front.sv =====
module cftg_front (
  input  logic              clk,
  input  logic              rst,
  input  cftg_pkg::cfg_t    cfg,
  input  logic              src_valid,
  output logic              src_stall,
  input  logic [1:0]        command,
  input  logic [7:0]        source_byte,
  input  logic              full,
  output logic              push,
  output cftg_pkg::job_t    job
);

  logic [1:0]  byte_phase, byte_phase_next;
  logic [7:0]  held_first, held_first_next;
  logic [7:0]  held_second, held_second_next;
  logic [24:0] pixels_emitted, pixels_emitted_next;

  logic        accept;
  logic [12:0] w_sat, h_sat;
  logic [25:0] prod;
  logic [24:0] total, pe_inc;
  logic        frame_full, fmt_ok, emit;

  assign src_stall = full;
  assign accept    = src_valid && !full;

  assign w_sat  = (cfg.frame_width  > cftg_pkg::MAX_WIDTH)  ? cftg_pkg::MAX_WIDTH
                                                             : cfg.frame_width;
  assign h_sat  = (cfg.frame_height > cftg_pkg::MAX_HEIGHT) ? cftg_pkg::MAX_HEIGHT
                                                             : cfg.frame_height;
  assign prod   = w_sat * h_sat;
  assign total  = prod[24:0];
  assign pe_inc = pixels_emitted + 25'd1;
  assign frame_full = (pixels_emitted >= total);
  assign fmt_ok = (cfg.format <= cftg_pkg::FMT_BGR);

  always_comb begin
    byte_phase_next     = byte_phase;
    held_first_next     = held_first;
    held_second_next    = held_second;
    pixels_emitted_next = pixels_emitted;
    emit                = 1'b0;
    job.luma = 1'b0;
    job.r    = 8'd0;
    job.g    = 8'd0;
    job.b    = 8'd0;
    job.last = (pe_inc == total);
    job.ok   = fmt_ok;
    if (command == cftg_pkg::CMD_START) begin
      byte_phase_next     = cftg_pkg::PH_FIRST;
      held_first_next     = 8'd0;
      held_second_next    = 8'd0;
      pixels_emitted_next = 25'd0;
    end else if (!frame_full) begin
      if (command == cftg_pkg::CMD_FILL) begin
        byte_phase_next = cftg_pkg::PH_FIRST;
        emit            = 1'b1;
      end else if (command == cftg_pkg::CMD_BYTE) begin
        case (cfg.format)
          cftg_pkg::FMT_YUYV: begin
            if (byte_phase != cftg_pkg::PH_SECOND) begin
              held_first_next = source_byte;
              byte_phase_next = cftg_pkg::PH_SECOND;
            end else begin
              byte_phase_next = cftg_pkg::PH_FIRST;
              job.r           = held_first;
              emit            = 1'b1;
            end
          end
          cftg_pkg::FMT_PLANAR: begin
            byte_phase_next = cftg_pkg::PH_FIRST;
            job.r           = source_byte;
            emit            = 1'b1;
          end
          cftg_pkg::FMT_RGB, cftg_pkg::FMT_BGR: begin
            if (byte_phase == cftg_pkg::PH_SECOND) begin
              held_second_next = source_byte;
              byte_phase_next  = cftg_pkg::PH_THIRD;
            end else if (byte_phase == cftg_pkg::PH_THIRD) begin
              byte_phase_next = cftg_pkg::PH_FIRST;
              job.luma        = 1'b1;
              job.g           = held_second;
              emit            = 1'b1;
              if (cfg.format == cftg_pkg::FMT_RGB) begin
                job.r = held_first;
                job.b = source_byte;
              end else begin
                job.r = source_byte;
                job.b = held_first;
              end
            end else begin
              held_first_next = source_byte;
              byte_phase_next = cftg_pkg::PH_SECOND;
            end
          end
          default: begin
          end
        endcase
      end
      if (emit) begin
        pixels_emitted_next = pe_inc;
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= cftg_pkg::PH_FIRST;
      held_first     <= 8'd0;
      held_second    <= 8'd0;
      pixels_emitted <= 25'd0;
    end else if (accept) begin
      byte_phase     <= byte_phase_next;
      held_first     <= held_first_next;
      held_second    <= held_second_next;
      pixels_emitted <= pixels_emitted_next;
    end
  end

endmodule

// ===== rtl/core/cftg_queue.sv =====
module cftg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cftg_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cftg_pkg::job_t head
);

  cftg_pkg::job_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/cftg_back.sv =====
module cftg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  cftg_pkg::job_t head,
  output logic           pop,
  output logic           pix_valid,
  input  logic           pix_stall,
  output logic [7:0]     gray_pixel,
  output logic           last_pixel,
  output logic           format_ok
);

  logic [23:0] prod_r, prod_g, prod_b;
  logic [24:0] sum;
  logic [7:0]  luma, pixel;

  assign prod_r = cftg_pkg::COEF_R * head.r;
  assign prod_g = cftg_pkg::COEF_G * head.g;
  assign prod_b = cftg_pkg::COEF_B * head.b;
  assign sum    = {1'b0, prod_r} + {1'b0, prod_g} + {1'b0, prod_b}
                  + cftg_pkg::LUMA_OFFSET;
  assign luma   = sum[24] ? 8'd255 : sum[23:16];
  assign pixel  = head.luma ? luma : head.r;

  assign pop = !empty && (!pix_valid || !pix_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pop) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      gray_pixel <= pixel;
      last_pixel <= head.last;
      format_ok  <= head.ok;
    end
  end

endmodule

// ===== rtl/core/camera_frame_to_gray_unit.sv =====
// Camera byte stream to 8-bit gray converter.
// Input channel (src_valid/src_stall): command plus source_byte. A start
// command resets the frame; source bytes form pixels per the format
// register (YUYV, planar/grey, RGB3, BGR3); fill commands give zero pixels.
// Output channel (pix_valid/pix_stall): gray_pixel, last_pixel, format_ok.
// Configuration goes through the APB port: format at 0x0, frame_width at
// 0x4, frame_height at 0x8. Write only while the block is idle.
// A pixel-completing byte is classified combinationally in the front and
// written to the queue; the back stage then computes luma and registers it.
// Throughput: one input transfer per cycle while src_stall is low; the front
// updates its state on each transfer and the back stage computes luma combinationally.
// A two-entry queue sits between front and back. When the receiver stalls,
// the output register holds, the queue fills, and src_stall rises once
// the queue is full.
// Reset: format YUYV, 640x480, pixel count and byte phase cleared, queue
// and output register empty.
module camera_frame_to_gray_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  source_byte,
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [7:0]  gray_pixel,
  output logic        last_pixel,
  output logic        format_ok
);

  cftg_pkg::cfg_t cfg;
  cftg_pkg::job_t push_job, head;
  logic           push, full, pop, empty, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format       <= cftg_pkg::RST_FORMAT;
      cfg.frame_width  <= cftg_pkg::RST_WIDTH;
      cfg.frame_height <= cftg_pkg::RST_HEIGHT;
    end else if (wr_en) begin
      case (paddr[3:2])
        cftg_pkg::REG_FORMAT: cfg.format       <= pwdata[2:0];
        cftg_pkg::REG_WIDTH:  cfg.frame_width  <= pwdata[12:0];
        cftg_pkg::REG_HEIGHT: cfg.frame_height <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cftg_pkg::REG_FORMAT: prdata = {29'd0, cfg.format};
      cftg_pkg::REG_WIDTH:  prdata = {19'd0, cfg.frame_width};
      cftg_pkg::REG_HEIGHT: prdata = {19'd0, cfg.frame_height};
      default:              prdata = 32'd0;
    endcase
  end

  cftg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .command     (command),
    .source_byte (source_byte),
    .full        (full),
    .push        (push),
    .job         (push_job)
  );

  cftg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  cftg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .gray_pixel (gray_pixel),
    .last_pixel (last_pixel),
    .format_ok  (format_ok)
  );

endmodule

// ===== tb/camera_frame_to_gray_unit_test.sv =====
module camera_frame_to_gray_unit_test;
  import cftg_pkg::*;

  localparam logic [1:0] CMD_NOP  = 2'd3;
  localparam logic [2:0] FMT_NONE = 3'd4;
  localparam logic [2:0] FMT_TOP  = 3'd7;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [7:0] gray;
    logic       last;
    logic       ok;
  } gray_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        src_valid;
  logic        src_stall;
  logic [1:0]  command;
  logic [7:0]  source_byte;
  logic        pix_valid;
  logic        pix_stall;
  logic [7:0]  gray_pixel;
  logic        last_pixel;
  logic        format_ok;

  // predictor state and its copy of the registers
  logic [2:0]  fmt_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  phase_q;
  logic [7:0]  first_q;
  logic [7:0]  second_q;
  logic [24:0] count_q;

  gray_result_t expected_pixels[$];
  int error_count = 0;
  bit steady = 1'b0;

  camera_frame_to_gray_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .command    (command),
    .source_byte(source_byte),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .gray_pixel (gray_pixel),
    .last_pixel (last_pixel),
    .format_ok  (format_ok)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("camera_frame_to_gray_unit_test: errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [12:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 13'd0;
    if (r < 75) return 13'($urandom_range(1, 6));
    if (r < 90) return 13'($urandom_range(7, 20));
    if (r < 95) return MAX_WIDTH;
    return 13'($urandom_range(4097, 8191));
  endfunction

  function automatic logic [31:0] frame_pixels();
    logic [31:0] w;
    logic [31:0] h;
    w = (width_q > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_q);
    h = (height_q > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_q);
    return w * h;
  endfunction

  function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [31:0] y;
    y = (32'(COEF_R) * 32'(r) + 32'(COEF_G) * 32'(g) + 32'(COEF_B) * 32'(b)
         + 32'(LUMA_OFFSET)) >> 16;
    return (y > 32'd255) ? 8'hFF : y[7:0];
  endfunction

  task automatic push_pixel(logic [7:0] v);
    gray_result_t e;
    logic [31:0] total;
    total = frame_pixels();
    count_q = count_q + 25'd1;
    e.gray = v;
    e.last = (32'(count_q) == total);
    e.ok   = (fmt_q <= FMT_BGR);
    expected_pixels.push_back(e);
  endtask

  task automatic predict_transfer(logic [1:0] cmd, logic [7:0] b);
    if (cmd == CMD_START) begin
      phase_q  = PH_FIRST;
      first_q  = 8'd0;
      second_q = 8'd0;
      count_q  = 25'd0;
    end else if (cmd != CMD_NOP && 32'(count_q) < frame_pixels()) begin
      if (cmd == CMD_FILL) begin
        phase_q = PH_FIRST;
        push_pixel(8'd0);
      end else begin
        case (fmt_q)
          FMT_YUYV: begin
            if (phase_q != PH_SECOND) begin
              first_q = b;
              phase_q = PH_SECOND;
            end else begin
              phase_q = PH_FIRST;
              push_pixel(first_q);
            end
          end
          FMT_PLANAR: begin
            phase_q = PH_FIRST;
            push_pixel(b);
          end
          FMT_RGB, FMT_BGR: begin
            if (phase_q == PH_SECOND) begin
              second_q = b;
              phase_q  = PH_THIRD;
            end else if (phase_q == PH_THIRD) begin
              phase_q = PH_FIRST;
              if (fmt_q == FMT_RGB) push_pixel(luma_of(first_q, second_q, b));
              else push_pixel(luma_of(b, second_q, first_q));
            end else begin
              first_q = b;
              phase_q = PH_SECOND;
            end
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic send_item(logic [1:0] cmd, logic [7:0] b);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid   <= 1'b1;
    command     <= cmd;
    source_byte <= b;
    do @(posedge clk); while (src_stall);
    predict_transfer(cmd, b);
  endtask

  // drop valid, wait for every pending pixel, then let the pipeline empty
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_pixels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FORMAT: fmt_q    = val[2:0];
      REG_WIDTH:  width_q  = val[12:0];
      REG_HEIGHT: height_q = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [2:0] f, logic [12:0] w, logic [12:0] h);
    settle();
    write_reg(REG_FORMAT, 32'(f));
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
  endtask

  // receiver: random stall bursts, none while steady
  initial begin
    int n;
    pix_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = steady ? 0 : pick_gap();
      if (n > 0) begin
        pix_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      pix_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_pixels
    gray_result_t want;
    if (!rst && pix_valid && !pix_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d", gray_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (gray_pixel !== want.gray)
          report_mismatch($sformatf("gray_pixel %0d, want %0d", gray_pixel, want.gray));
        if (last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel %0b, want %0b", last_pixel, want.last));
        if (format_ok !== want.ok)
          report_mismatch($sformatf("format_ok %0b, want %0b", format_ok, want.ok));
      end
    end
  end

  // YUYV 640x480 straight out of reset, no start command
  task automatic test_reset_defaults();
    send_item(CMD_BYTE, 8'h12);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
  endtask

  task automatic test_corner_cases();
    // planar extremes, frame full, drops after the last pixel
    configure(FMT_PLANAR, 13'd2, 13'd1);
    send_item(CMD_START, 8'hAA);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h07);
    send_item(CMD_FILL, 8'h00);
    // RGB extremes, fill after partial pixel
    configure(FMT_RGB, 13'd3, 13'd1);
    send_item(CMD_START, 8'h00);
    repeat (3) send_item(CMD_BYTE, 8'hFF);
    repeat (3) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hC8);
    send_item(CMD_FILL, 8'h55);
    // BGR order, ignored command, restart mid-pixel
    configure(FMT_BGR, 13'd2, 13'd1);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h0A);
    send_item(CMD_NOP, 8'hFF);
    send_item(CMD_BYTE, 8'h14);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h0A);
    send_item(CMD_BYTE, 8'h14);
    send_item(CMD_BYTE, 8'hFA);
    // format change mid-pixel, both directions
    configure(FMT_YUYV, 13'd4, 13'd1);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h64);
    settle();
    write_reg(REG_FORMAT, 32'(FMT_RGB));
    send_item(CMD_BYTE, 8'h32);
    send_item(CMD_BYTE, 8'h3C);
    send_item(CMD_BYTE, 8'h01);
    send_item(CMD_BYTE, 8'h02);
    settle();
    write_reg(REG_FORMAT, 32'(FMT_YUYV));
    send_item(CMD_BYTE, 8'h77);
    send_item(CMD_BYTE, 8'h88);
    // unsupported formats
    configure(FMT_NONE, 13'd2, 13'd1);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h99);
    send_item(CMD_FILL, 8'h00);
    send_item(CMD_FILL, 8'h00);
    configure(FMT_TOP, 13'd3, 13'd3);
    send_item(CMD_START, 8'h00);
    send_item(CMD_FILL, 8'h00);
    // zero dimensions
    configure(FMT_PLANAR, 13'd0, 13'd5);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h11);
    send_item(CMD_FILL, 8'h00);
    configure(FMT_PLANAR, 13'd5, 13'd0);
    send_item(CMD_START, 8'h00);
    send_item(CMD_FILL, 8'h00);
  endtask

  // oversize width, then height: no early last_pixel from the clamped product
  task automatic test_dimension_clamp();
    configure(FMT_PLANAR, 13'h1FFF, 13'd1);
    send_item(CMD_START, 8'h00);
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_item(CMD_FILL, rand_byte());
      else send_item(CMD_BYTE, rand_byte());
    end
    configure(FMT_PLANAR, 13'd1, 13'h1FFF);
    send_item(CMD_START, 8'h00);
    repeat (40) send_item(CMD_FILL, 8'h00);
  endtask

  task automatic test_random_frames();
    int sent;
    int npix;
    int nbytes;
    int bpp;
    int roll;
    int fill_pct;
    logic [2:0] f;
    sent = 0;
    while (sent < 1380) begin
      if ($urandom_range(0, 9) == 0) f = 3'($urandom_range(4, 7));
      else f = 3'($urandom_range(0, 3));
      steady = ($urandom_range(0, 4) == 0);
      configure(f, pick_dim(), pick_dim());
      repeat ($urandom_range(1, 3)) begin
        send_item(CMD_START, rand_byte());
        sent++;
        npix = (frame_pixels() > 32'd30) ? 30 : int'(frame_pixels());
        bpp = (f == FMT_YUYV) ? 2 : (f == FMT_RGB || f == FMT_BGR) ? 3 : 1;
        nbytes = (npix + $urandom_range(0, 2)) * bpp;
        for (int i = 0; i < nbytes; i++) begin
          fill_pct = (f > FMT_BGR) ? 60 : 4;
          roll = $urandom_range(0, 99);
          if (roll < fill_pct) begin
            send_item(CMD_FILL, rand_byte());
          end else if (roll < fill_pct + 2) begin
            send_item(CMD_NOP, rand_byte());
          end else if (roll < fill_pct + 3) begin
            send_item(CMD_START, rand_byte());
          end else if (roll < fill_pct + 4) begin
            settle();
            f = 3'($urandom_range(0, 7));
            write_reg(REG_FORMAT, 32'(f));
          end else begin
            send_item(CMD_BYTE, rand_byte());
          end
          sent++;
        end
        if ($urandom_range(0, 3) == 0) settle();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 4'd0;
    pwdata      = 32'd0;
    src_valid   = 1'b0;
    command     = CMD_START;
    source_byte = 8'd0;
    fmt_q       = RST_FORMAT;
    width_q     = RST_WIDTH;
    height_q    = RST_HEIGHT;
    phase_q     = PH_FIRST;
    first_q     = 8'd0;
    second_q    = 8'd0;
    count_q     = 25'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_corner_cases();
    test_dimension_clamp();
    test_random_frames();

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("camera_frame_to_gray_unit_test: clean");
    end else begin
      $display("camera_frame_to_gray_unit_test: errors");
    end
    $finish;
  end

endmodule
